>>> hw/rtl/ccfc_pkg.sv
// ----------------------------------------------------------------------------
// ccfc_pkg
// Shared types and constants of the character counting flow control block:
// event and verdict codes, channel payloads and charge fifo control.
// ----------------------------------------------------------------------------
`default_nettype none

package ccfc_pkg;

  // default charge fifo depth
  localparam int unsigned FIFO_DEPTH_DEF = 128;

  // field widths
  localparam int unsigned KIND_W    = 4;
  localparam int unsigned LEN_W     = 10;
  localparam int unsigned LINES_W   = 16;
  localparam int unsigned ECODE_W   = 8;
  localparam int unsigned VERDICT_W = 3;
  localparam int unsigned BYTES_W   = 11;
  localparam int unsigned CHARGE_W  = 11;
  localparam int unsigned LIF_W     = 11;
  localparam int unsigned TCOUNT_W  = 8;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_RX_BUFFER_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_LIMIT   = 2'd1;

  localparam logic [BYTES_W-1:0]  RX_BUFFER_BYTES_RST = 11'd128;
  localparam logic [TCOUNT_W-1:0] TIMEOUT_LIMIT_RST   = 8'd25;

  // event kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_START       = 4'd0,
    KIND_OFFER       = 4'd1,
    KIND_ACK_OK      = 4'd2,
    KIND_ACK_ERROR   = 4'd3,
    KIND_ALARM       = 4'd4,
    KIND_QUERY_SENT  = 4'd5,
    KIND_STATUS_SEEN = 4'd6,
    KIND_TIMEOUT     = 4'd7,
    KIND_HOLD        = 4'd8,
    KIND_TOOL_ACK    = 4'd9,
    KIND_CLEAR_ERROR = 4'd10,
    KIND_DISCONNECT  = 4'd11
  } kind_t;

  // offer verdicts
  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_NONE    = 3'd0,
    VERDICT_SENT    = 3'd1,
    VERDICT_FULL    = 3'd2,
    VERDICT_TOOL    = 3'd3,
    VERDICT_BLOCKED = 3'd4
  } verdict_t;

  // input item
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [LEN_W-1:0]   line_length;
    logic               is_tool_change;
    logic [LINES_W-1:0] program_lines;
    logic [ECODE_W-1:0] error_code;
    logic               hold_value;
  } in_data_t;

  // result item
  typedef struct packed {
    logic [VERDICT_W-1:0] verdict;
    logic [LINES_W-1:0]   acked_line_index;
    logic                 ack_is_error;
    logic [ECODE_W-1:0]   failed_error_code;
    logic                 request_soft_reset;
    logic                 stream_active;
    logic                 in_error_state;
    logic                 tool_wait;
    logic [BYTES_W-1:0]   bytes_in_use;
    logic [LIF_W-1:0]     lines_in_flight;
    logic [LINES_W-1:0]   next_send_index;
    logic                 link_lost;
  } out_data_t;

  // charge fifo control, one step at a time
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } fifo_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/ccfc_if.sv
// ----------------------------------------------------------------------------
// ccfc_if
// Valid/ready channel interfaces: event input, result output and
// configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface ccfc_in_if import ccfc_pkg::*; ();
  logic     valid;
  logic     ready;
  in_data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ccfc_out_if import ccfc_pkg::*; ();
  logic      valid;
  logic      ready;
  out_data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ccfc_cfg_if import ccfc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/ccfc_ram.sv
// ----------------------------------------------------------------------------
// ccfc_ram
// Generic single write port, single read port RAM with registered read.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module ccfc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> hw/rtl/ccfc_charge_fifo.sv
// ----------------------------------------------------------------------------
// ccfc_charge_fifo
// Fifo of per-line byte charges on a RAM. The head entry is read ahead so
// its charge is ready in the cycle of a pop; a push into the head slot is
// forwarded around the RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module ccfc_charge_fifo import ccfc_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF,
  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH),
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1)
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire fifo_ctl_t           ctl,
  input  wire logic [CHARGE_W-1:0] push_charge,
  output logic      [CHARGE_W-1:0] head_charge,
  output logic      [CNT_W-1:0]    count
);

  logic [PTR_W-1:0]    head_r, head_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [PTR_W:0]      tail_sum;
  logic [PTR_W-1:0]    tail;
  logic                byp_valid_r;
  logic [CHARGE_W-1:0] byp_data_r;
  logic [CHARGE_W-1:0] rd_data;

  // tail slot, head plus count wrapped at the depth
  always_comb begin
    tail_sum = (PTR_W + 1)'(head_r) + (PTR_W + 1)'(count_r);
    if (tail_sum >= (PTR_W + 1)'(FIFO_DEPTH)) begin
      tail = PTR_W'(tail_sum - (PTR_W + 1)'(FIFO_DEPTH));
    end else begin
      tail = PTR_W'(tail_sum);
    end
  end

  // pointer and count update, clear wins
  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (ctl.clear) begin
      head_nxt  = '0;
      count_nxt = '0;
    end else if (ctl.push) begin
      count_nxt = count_r + 1'b1;
    end else if (ctl.pop) begin
      head_nxt  = (head_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head_r + 1'b1;
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      byp_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      byp_valid_r <= ctl.push && !ctl.clear && (tail == head_nxt);
    end
  end

  // forwarded charge for a push into the slot being read ahead
  always_ff @(posedge clk) begin
    byp_data_r <= push_charge;
  end

  ccfc_ram #(
    .WIDTH (CHARGE_W),
    .DEPTH (FIFO_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ctl.push),
    .wr_addr (tail),
    .wr_data (push_charge),
    .rd_addr (head_nxt),
    .rd_data (rd_data)
  );

  assign head_charge = byp_valid_r ? byp_data_r : rd_data;
  assign count       = count_r;

  // occupancy stays within the depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(FIFO_DEPTH))
    else $error("charge fifo count above depth");

  // no push into a full fifo
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.push |-> count_r != CNT_W'(FIFO_DEPTH))
    else $error("charge fifo push while full");

  // no pop from an empty fifo
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.pop && !ctl.clear |-> count_r != '0)
    else $error("charge fifo pop while empty");

endmodule

`default_nettype wire

>>> hw/rtl/char_count_stream_flow_control_unit.sv
// ----------------------------------------------------------------------------
// char_count_stream_flow_control_unit
// Path: an event is taken into the input register, then one step of flow
//   control logic writes its result into the result register.
// Throughput: one event per cycle unless the result register stalls, set by
//   the single-step state update and the read-ahead head port of the charge fifo RAM.
// Reset: counters, flags and fifo pointers clear at once; buffer size 128
//   and timeout limit 25; fifo RAM contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module char_count_stream_flow_control_unit import ccfc_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  ccfc_in_if.sink     in_if,
  ccfc_out_if.source  out_if,
  ccfc_cfg_if.sink    cfg_if
);

  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  // configuration registers
  logic [BYTES_W-1:0]  rx_bytes_r;
  logic [TCOUNT_W-1:0] tlimit_r;

  // input and result registers
  logic      inq_valid_r;
  in_data_t  inq_r;
  logic      out_valid_r;
  out_data_t out_data_r, out_nxt;
  logic      step;

  // flow control state
  logic [BYTES_W-1:0]  used_r, used_nxt;
  logic [LINES_W-1:0]  send_r, send_nxt;
  logic [LINES_W-1:0]  ack_r, ack_nxt;
  logic [LINES_W-1:0]  total_r, total_nxt;
  logic                streaming_r, streaming_nxt;
  logic                held_r, held_nxt;
  logic                tool_r, tool_nxt;
  logic                error_r, error_nxt;
  logic                query_r, query_nxt;
  logic [TCOUNT_W-1:0] tcount_r, tcount_nxt;

  // charge fifo
  fifo_ctl_t           fctl;
  logic [CHARGE_W-1:0] charge;
  logic [CHARGE_W-1:0] head_charge;
  logic [CNT_W-1:0]    fcount, fcount_pop, fcount_nxt;

  // helpers
  logic [BYTES_W:0]    room_sum;
  logic [BYTES_W-1:0]  used_pop;
  logic [LINES_W-1:0]  ack_sat;
  logic [TCOUNT_W-1:0] tcount_inc;
  logic                flight_ovr;
  logic [CNT_W-1:0]    flight_val;

  // handshakes
  assign step         = inq_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready  = !inq_valid_r || step;
  assign cfg_if.ready = 1'b1;
  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_data_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_bytes_r <= RX_BUFFER_BYTES_RST;
      tlimit_r   <= TIMEOUT_LIMIT_RST;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        CFG_RX_BUFFER_BYTES: rx_bytes_r <= cfg_if.data;
        CFG_TIMEOUT_LIMIT:   tlimit_r   <= cfg_if.data[TCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // shared arithmetic
  assign charge     = {1'b0, inq_r.line_length} + CHARGE_W'(1);
  assign room_sum   = {1'b0, used_r} + {1'b0, charge};
  assign fcount_pop = (fcount != '0) ? fcount - 1'b1 : fcount;
  assign ack_sat    = (ack_r == '1) ? ack_r : ack_r + 1'b1;
  assign tcount_inc = (tcount_r == '1) ? tcount_r : tcount_r + 1'b1;

  always_comb begin
    if (fcount == '0) begin
      used_pop = used_r;
    end else if (used_r >= head_charge) begin
      used_pop = used_r - head_charge;
    end else begin
      used_pop = '0;
    end
  end

  // one event step
  always_comb begin
    used_nxt      = used_r;
    send_nxt      = send_r;
    ack_nxt       = ack_r;
    total_nxt     = total_r;
    streaming_nxt = streaming_r;
    held_nxt      = held_r;
    tool_nxt      = tool_r;
    error_nxt     = error_r;
    query_nxt     = query_r;
    tcount_nxt    = tcount_r;
    fctl          = '0;
    flight_ovr    = 1'b0;
    flight_val    = '0;
    out_nxt       = '0;
    out_nxt.verdict = VERDICT_NONE;

    if (step) begin
      unique case (kind_t'(inq_r.kind))
        KIND_START: begin
          if (!error_r) begin
            total_nxt     = inq_r.program_lines;
            send_nxt      = '0;
            ack_nxt       = '0;
            fctl.clear    = 1'b1;
            used_nxt      = '0;
            held_nxt      = 1'b0;
            tool_nxt      = 1'b0;
            streaming_nxt = inq_r.program_lines != '0;
          end
        end
        KIND_OFFER: begin
          if (!streaming_r || held_r || tool_r || send_r >= total_r) begin
            out_nxt.verdict = VERDICT_BLOCKED;
          end else if (inq_r.is_tool_change) begin
            tool_nxt        = 1'b1;
            out_nxt.verdict = VERDICT_TOOL;
          end else if (room_sum > {1'b0, rx_bytes_r} || fcount == CNT_W'(FIFO_DEPTH)) begin
            out_nxt.verdict = VERDICT_FULL;
          end else begin
            fctl.push       = 1'b1;
            used_nxt        = room_sum[BYTES_W-1:0];
            send_nxt        = send_r + 1'b1;
            out_nxt.verdict = VERDICT_SENT;
          end
        end
        KIND_ACK_OK, KIND_ACK_ERROR: begin
          tcount_nxt               = '0;
          out_nxt.acked_line_index = ack_r;
          if (inq_r.kind == KIND_ACK_ERROR) begin
            out_nxt.ack_is_error      = 1'b1;
            out_nxt.failed_error_code = inq_r.error_code;
          end
          if (inq_r.kind == KIND_ACK_ERROR && streaming_r) begin
            // streaming error: abort and flush
            out_nxt.request_soft_reset = 1'b1;
            flight_ovr    = 1'b1;
            flight_val    = fcount_pop;
            streaming_nxt = 1'b0;
            held_nxt      = 1'b0;
            fctl.clear    = 1'b1;
            used_nxt      = '0;
            error_nxt     = 1'b1;
          end else begin
            fctl.pop = fcount != '0;
            used_nxt = used_pop;
            ack_nxt  = ack_sat;
            // stream ends on the last ack or when all is sent and drained
            if (streaming_r && (ack_sat >= total_r ||
                                (send_r >= total_r && fcount_pop == '0))) begin
              streaming_nxt = 1'b0;
            end
          end
        end
        KIND_ALARM: begin
          tcount_nxt    = '0;
          streaming_nxt = 1'b0;
        end
        KIND_QUERY_SENT: begin
          query_nxt = 1'b1;
        end
        KIND_STATUS_SEEN: begin
          query_nxt  = 1'b0;
          tcount_nxt = '0;
        end
        KIND_TIMEOUT: begin
          if (query_r) begin
            tcount_nxt = tcount_inc;
            if (tcount_inc >= tlimit_r) begin
              streaming_nxt     = 1'b0;
              held_nxt          = 1'b0;
              fctl.clear        = 1'b1;
              used_nxt          = '0;
              query_nxt         = 1'b0;
              tcount_nxt        = '0;
              out_nxt.link_lost = 1'b1;
            end
          end
        end
        KIND_HOLD: begin
          held_nxt = inq_r.hold_value;
        end
        KIND_TOOL_ACK: begin
          // the tool change line itself is skipped
          if (tool_r) begin
            tool_nxt = 1'b0;
            if (send_r < total_r) begin
              send_nxt = send_r + 1'b1;
            end
          end
        end
        KIND_CLEAR_ERROR: begin
          error_nxt = 1'b0;
        end
        KIND_DISCONNECT: begin
          streaming_nxt     = 1'b0;
          held_nxt          = 1'b0;
          fctl.clear        = 1'b1;
          used_nxt          = '0;
          query_nxt         = 1'b0;
          tcount_nxt        = '0;
          error_nxt         = 1'b0;
          out_nxt.link_lost = 1'b1;
        end
        default: ;
      endcase
    end

    // fifo occupancy after the step
    if (fctl.clear) begin
      fcount_nxt = '0;
    end else if (fctl.push) begin
      fcount_nxt = fcount + 1'b1;
    end else if (fctl.pop) begin
      fcount_nxt = fcount - 1'b1;
    end else begin
      fcount_nxt = fcount;
    end

    out_nxt.stream_active   = streaming_nxt;
    out_nxt.in_error_state  = error_nxt;
    out_nxt.tool_wait       = tool_nxt;
    out_nxt.bytes_in_use    = used_nxt;
    out_nxt.lines_in_flight = flight_ovr ? LIF_W'(flight_val) : LIF_W'(fcount_nxt);
    out_nxt.next_send_index = send_nxt;
  end

  ccfc_charge_fifo #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_charge_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (fctl),
    .push_charge (charge),
    .head_charge (head_charge),
    .count       (fcount)
  );

  // control state and valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      used_r      <= '0;
      send_r      <= '0;
      ack_r       <= '0;
      total_r     <= '0;
      streaming_r <= 1'b0;
      held_r      <= 1'b0;
      tool_r      <= 1'b0;
      error_r     <= 1'b0;
      query_r     <= 1'b0;
      tcount_r    <= '0;
    end else begin
      if (in_if.ready) begin
        inq_valid_r <= in_if.valid;
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      used_r      <= used_nxt;
      send_r      <= send_nxt;
      ack_r       <= ack_nxt;
      total_r     <= total_nxt;
      streaming_r <= streaming_nxt;
      held_r      <= held_nxt;
      tool_r      <= tool_nxt;
      error_r     <= error_nxt;
      query_r     <= query_nxt;
      tcount_r    <= tcount_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_if.ready) begin
      inq_r <= in_if.data;
    end
    if (step) begin
      out_data_r <= out_nxt;
    end
  end

  // a soft reset request always leaves the stream stopped in error state
  a_sreset_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.request_soft_reset |->
      out_data_r.in_error_state && !out_data_r.stream_active)
    else $error("soft reset request without error state");

  // a dropped link leaves nothing charged
  a_link_lost_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.link_lost |->
      !out_data_r.stream_active && out_data_r.bytes_in_use == '0 &&
      out_data_r.lines_in_flight == '0)
    else $error("link drop left stream state behind");

  // state moves only on a step
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(send_r) && $stable(ack_r) && $stable(used_r))
    else $error("flow control state changed without an event");

endmodule

`default_nettype wire

>>> tb/sv/char_count_stream_flow_control_unit_test.sv
// ----------------------------------------------------------------------------
// char_count_stream_flow_control_unit_test
// Self-checking bench for the character counting flow control block. A
// queue-fed driver offers events in random bursts, a monitor checks every
// result against an in-bench prediction of the credit accounting, and the
// run steps through several buffer size and timeout limit settings.
// ----------------------------------------------------------------------------
module char_count_stream_flow_control_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ccfc_pkg::*;

  localparam int unsigned CREDIT_DEPTH = FIFO_DEPTH_DEF;
  localparam int          LONG_HOLD    = 300;
  localparam int          EV_SLOTS     = 2048;
  localparam int          STATUS_SLOTS = 64;

  // event code outside the defined kinds
  localparam logic [KIND_W-1:0] KIND_SPARE = 4'hF;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // bench side of the channels
  logic                  in_valid_d  = 1'b0;
  in_data_t              in_data_d   = '0;
  logic                  out_ready_d = 1'b0;
  logic                  cfg_valid_d = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_d = '0;
  logic [CFG_DATA_W-1:0] cfg_data_d  = '0;

  ccfc_in_if  in_ch ();
  ccfc_out_if out_ch ();
  ccfc_cfg_if cfg_ch ();

  assign in_ch.valid  = in_valid_d;
  assign in_ch.data   = in_data_d;
  assign out_ch.ready = out_ready_d;
  assign cfg_ch.valid = cfg_valid_d;
  assign cfg_ch.index = cfg_index_d;
  assign cfg_ch.data  = cfg_data_d;

  char_count_stream_flow_control_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  always #5 clk = ~clk;

  // predicted state of the flow control
  logic [CHARGE_W-1:0] credit_fifo [CREDIT_DEPTH];
  int unsigned         credit_head    = 0;
  int unsigned         credit_count   = 0;
  logic [BYTES_W-1:0]  bytes_charged  = '0;
  logic [LINES_W-1:0]  lines_sent     = '0;
  logic [LINES_W-1:0]  lines_acked    = '0;
  logic [LINES_W-1:0]  prog_total     = '0;
  logic                stream_on      = 1'b0;
  logic                feed_held      = 1'b0;
  logic                tool_hold      = 1'b0;
  logic                err_state      = 1'b0;
  logic                query_out      = 1'b0;
  logic [TCOUNT_W-1:0] missed_replies = '0;
  logic [BYTES_W-1:0]  rx_bytes       = RX_BUFFER_BYTES_RST;
  logic [TCOUNT_W-1:0] timeout_lim    = TIMEOUT_LIMIT_RST;

  // pending events and expected results, ring buffers with running counters
  in_data_t  event_buf  [EV_SLOTS];
  int        ev_wr      = 0;
  int        ev_rd      = 0;
  out_data_t status_buf [STATUS_SLOTS];
  int        st_wr      = 0;
  int        st_rd      = 0;
  int        mismatches = 0;

  // driver and receiver control
  logic     in_busy        = 1'b0;
  logic     in_fire        = 1'b0;
  logic     free_run       = 1'b0;
  int       burst_left     = 0;
  int       gap_left       = 0;
  logic     drv_valid;
  in_data_t drv_data;
  int       long_hold_seq  = 0;
  int       long_hold_seen = 0;
  int       rx_hold_left   = 0;
  int       rx_pattern_age = 0;
  logic [15:0] rx_pattern  = '1;
  logic     rx_ready;

  function automatic void flush_credits();
    credit_head   = 0;
    credit_count  = 0;
    bytes_charged = '0;
  endfunction

  function automatic void drop_link_state();
    stream_on      = 1'b0;
    feed_held      = 1'b0;
    flush_credits();
    query_out      = 1'b0;
    missed_replies = '0;
  endfunction

  // append one event for the driver
  function automatic void add_event(in_data_t it);
    event_buf[ev_wr % EV_SLOTS] = it;
    ev_wr++;
  endfunction

  // one event of the flow control, returns the status it reports
  function automatic out_data_t predict_flow_step(in_data_t ev);
    out_data_t           res;
    logic [CHARGE_W-1:0] charge;
    logic [CHARGE_W-1:0] released;
    logic                abort;
    int unsigned         flight_left;
    res         = '0;
    abort       = 1'b0;
    flight_left = 0;
    charge      = {1'b0, ev.line_length} + 11'd1;
    case (ev.kind)
      KIND_START: begin
        if (!err_state) begin
          prog_total  = ev.program_lines;
          lines_sent  = '0;
          lines_acked = '0;
          flush_credits();
          feed_held   = 1'b0;
          tool_hold   = 1'b0;
          stream_on   = (ev.program_lines != '0);
        end
      end
      KIND_OFFER: begin
        if (!stream_on || feed_held || tool_hold || lines_sent >= prog_total) begin
          res.verdict = VERDICT_BLOCKED;
        end else if (ev.is_tool_change) begin
          tool_hold   = 1'b1;
          res.verdict = VERDICT_TOOL;
        end else if (int'(bytes_charged) + int'(charge) > int'(rx_bytes) ||
                     credit_count >= CREDIT_DEPTH) begin
          res.verdict = VERDICT_FULL;
        end else begin
          credit_fifo[(credit_head + credit_count) % CREDIT_DEPTH] = charge;
          credit_count++;
          bytes_charged = bytes_charged + charge;
          lines_sent    = lines_sent + 1'b1;
          res.verdict   = VERDICT_SENT;
        end
      end
      KIND_ACK_OK, KIND_ACK_ERROR: begin
        missed_replies = '0;
        if (credit_count > 0) begin
          released      = credit_fifo[credit_head];
          bytes_charged = (bytes_charged >= released) ? bytes_charged - released : '0;
          credit_head   = (credit_head + 1) % CREDIT_DEPTH;
          credit_count--;
        end
        res.acked_line_index = lines_acked;
        if (ev.kind == KIND_ACK_ERROR) begin
          res.ack_is_error      = 1'b1;
          res.failed_error_code = ev.error_code;
        end
        if (ev.kind == KIND_ACK_ERROR && stream_on) begin
          // streaming error aborts and reports the lines left before clearing
          res.request_soft_reset = 1'b1;
          abort       = 1'b1;
          flight_left = credit_count;
          stream_on   = 1'b0;
          feed_held   = 1'b0;
          flush_credits();
          err_state   = 1'b1;
        end else begin
          if (lines_acked != '1) lines_acked = lines_acked + 1'b1;
          if (stream_on && (lines_acked >= prog_total ||
                            (lines_sent >= prog_total && credit_count == 0)))
            stream_on = 1'b0;
        end
      end
      KIND_ALARM: begin
        missed_replies = '0;
        stream_on      = 1'b0;
      end
      KIND_QUERY_SENT: query_out = 1'b1;
      KIND_STATUS_SEEN: begin
        query_out      = 1'b0;
        missed_replies = '0;
      end
      KIND_TIMEOUT: begin
        if (query_out) begin
          if (missed_replies != '1) missed_replies = missed_replies + 1'b1;
          if (missed_replies >= timeout_lim) begin
            drop_link_state();
            res.link_lost = 1'b1;
          end
        end
      end
      KIND_HOLD: feed_held = ev.hold_value;
      KIND_TOOL_ACK: begin
        // the tool change line itself is skipped, never charged
        if (tool_hold) begin
          tool_hold = 1'b0;
          if (lines_sent < prog_total) lines_sent = lines_sent + 1'b1;
        end
      end
      KIND_CLEAR_ERROR: err_state = 1'b0;
      KIND_DISCONNECT: begin
        drop_link_state();
        err_state     = 1'b0;
        res.link_lost = 1'b1;
      end
      default: ;
    endcase
    res.stream_active   = stream_on;
    res.in_error_state  = err_state;
    res.tool_wait       = tool_hold;
    res.bytes_in_use    = bytes_charged;
    res.lines_in_flight = abort ? LIF_W'(flight_left) : LIF_W'(credit_count);
    res.next_send_index = lines_sent;
    return res;
  endfunction

  function automatic void check_field(string fname, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s expected %0d actual %0d", $time, fname, want, got);
    end
  endfunction

  // input transfers feed the prediction, output transfers are checked
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        in_fire = 1'b1;
        status_buf[st_wr % STATUS_SLOTS] = predict_flow_step(in_ch.data);
        st_wr++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (st_wr == st_rd) begin
          mismatches++;
          $display("%0t ns: result expected none actual %h", $time, out_ch.data);
        end else begin
          out_data_t want;
          want = status_buf[st_rd % STATUS_SLOTS];
          st_rd++;
          check_field("verdict", want.verdict, out_ch.data.verdict);
          check_field("acked_line_index", want.acked_line_index,
                      out_ch.data.acked_line_index);
          check_field("ack_is_error", want.ack_is_error, out_ch.data.ack_is_error);
          check_field("failed_error_code", want.failed_error_code,
                      out_ch.data.failed_error_code);
          check_field("request_soft_reset", want.request_soft_reset,
                      out_ch.data.request_soft_reset);
          check_field("stream_active", want.stream_active, out_ch.data.stream_active);
          check_field("in_error_state", want.in_error_state, out_ch.data.in_error_state);
          check_field("tool_wait", want.tool_wait, out_ch.data.tool_wait);
          check_field("bytes_in_use", want.bytes_in_use, out_ch.data.bytes_in_use);
          check_field("lines_in_flight", want.lines_in_flight,
                      out_ch.data.lines_in_flight);
          check_field("next_send_index", want.next_send_index,
                      out_ch.data.next_send_index);
          check_field("link_lost", want.link_lost, out_ch.data.link_lost);
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == CFG_RX_BUFFER_BYTES) rx_bytes = cfg_ch.data[BYTES_W-1:0];
        else if (cfg_ch.index == CFG_TIMEOUT_LIMIT) timeout_lim = cfg_ch.data[TCOUNT_W-1:0];
      end
    end
  end

  // driver: bursts of events with random gaps in between
  always @(negedge clk) begin
    drv_valid = in_valid_d;
    drv_data  = in_data_d;
    if (in_fire) begin
      in_fire   = 1'b0;
      in_busy   = 1'b0;
      drv_valid = 1'b0;
    end
    if (!in_busy && rst_n) begin
      if (gap_left > 0 && !free_run) begin
        gap_left--;
      end else if (ev_wr != ev_rd) begin
        drv_data  = event_buf[ev_rd % EV_SLOTS];
        ev_rd++;
        drv_valid = 1'b1;
        in_busy   = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
    in_valid_d <= drv_valid;
    in_data_d  <= drv_data;
  end

  // receiver: rotating stall pattern, plus an occasional long hold-off
  always @(negedge clk) begin
    if (long_hold_seq != long_hold_seen) begin
      long_hold_seen = long_hold_seq;
      rx_hold_left   = LONG_HOLD;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      rx_ready = 1'b0;
    end else if (free_run) begin
      rx_ready = 1'b1;
    end else begin
      if (rx_pattern_age == 0) begin
        rx_pattern_age = 64;
        case ($urandom_range(0, 3))
          0:       rx_pattern = '1;
          1:       rx_pattern = 16'($urandom) | 16'h0101;
          2:       rx_pattern = 16'($urandom) | 16'($urandom);
          default: rx_pattern = 16'hF0FF;
        endcase
      end
      rx_pattern_age--;
      rx_ready   = rx_pattern[0];
      rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
    end
    out_ready_d <= rx_ready;
  end

  function automatic in_data_t make_event(logic [KIND_W-1:0] kind, int len = 0,
                                          logic m6 = 1'b0, int prog = 0,
                                          int ecode = 0, logic hold = 1'b0);
    in_data_t it;
    it.kind           = kind;
    it.line_length    = LEN_W'(len);
    it.is_tool_change = m6;
    it.program_lines  = LINES_W'(prog);
    it.error_code     = ECODE_W'(ecode);
    it.hold_value     = hold;
    return it;
  endfunction

  // random content in every field, unused ones included
  function automatic in_data_t rand_event(logic [KIND_W-1:0] kind);
    logic [63:0] bits;
    in_data_t    it;
    bits    = {$urandom, $urandom};
    it      = bits[$bits(in_data_t)-1:0];
    it.kind = kind;
    return it;
  endfunction

  function automatic logic [LINES_W-1:0] pick_prog();
    int p;
    p = $urandom_range(0, 99);
    if (p < 70) return LINES_W'($urandom_range(1, 40));
    if (p < 90) return LINES_W'($urandom_range(40, 300));
    if (p < 95) return '0;
    return LINES_W'($urandom);
  endfunction

  function automatic logic [LEN_W-1:0] pick_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 75) return LEN_W'($urandom_range(0, 20));
    if (p < 90) return LEN_W'($urandom_range(20, 200));
    return LEN_W'($urandom_range(0, 1023));
  endfunction

  // one stream session: an optional clear error, a start, then a weighted mix of events
  task automatic add_session(int n);
    in_data_t it;
    int       pick;
    if ($urandom_range(0, 1)) add_event(rand_event(KIND_CLEAR_ERROR));
    it = rand_event(KIND_START);
    it.program_lines = pick_prog();
    add_event(it);
    repeat (n) begin
      pick = $urandom_range(0, 999);
      it   = rand_event(KIND_OFFER);
      if (pick < 450) begin
        it.is_tool_change = ($urandom_range(0, 99) < 5);
        it.line_length    = pick_len();
      end else if (pick < 750) it.kind = KIND_ACK_OK;
      else if (pick < 790) begin
        it.kind       = KIND_HOLD;
        it.hold_value = ($urandom_range(0, 9) < 3);
      end
      else if (pick < 830) it.kind = KIND_TOOL_ACK;
      else if (pick < 870) it.kind = KIND_QUERY_SENT;
      else if (pick < 900) it.kind = KIND_STATUS_SEEN;
      else if (pick < 950) it.kind = KIND_TIMEOUT;
      else if (pick < 962) it.kind = KIND_ACK_ERROR;
      else if (pick < 972) it.kind = KIND_ALARM;
      else if (pick < 977) it.kind = KIND_DISCONNECT;
      else if (pick < 987) it.kind = KIND_CLEAR_ERROR;
      else if (pick < 994) begin
        it.kind          = KIND_START;
        it.program_lines = pick_prog();
      end
      else it.kind = KIND_W'($urandom_range(12, 15));
      add_event(it);
    end
  endtask

  // sessions until about n_items events are queued
  task automatic add_random_phase(int n_items);
    int target;
    int len;
    target = ev_wr + n_items;
    while (ev_wr < target) begin
      len = int'($urandom_range(20, 80));
      if (len > target - ev_wr) len = target - ev_wr;
      add_session(len);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid_d <= 1'b1;
    cfg_index_d <= idx;
    cfg_data_d  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_valid_d <= 1'b0;
  endtask

  // wait until every queued event is sent and every pending status has come back
  task automatic wait_idle();
    while (ev_wr != ev_rd || in_busy || st_wr != st_rd)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: buffer edges, tool change, hold, timeouts, errors
    write_reg(CFG_RX_BUFFER_BYTES, 11'd128);
    write_reg(CFG_TIMEOUT_LIMIT, 11'd2);
    add_event(make_event(KIND_START, 0, 0, 0));
    add_event(make_event(KIND_START, 0, 0, 65535));
    add_event(make_event(KIND_OFFER, 1023));
    add_event(make_event(KIND_OFFER, 0));
    add_event(make_event(KIND_OFFER, 126));
    add_event(make_event(KIND_OFFER, 0));
    add_event(make_event(KIND_OFFER, 0, 1));
    add_event(make_event(KIND_OFFER, 0));
    add_event(make_event(KIND_TOOL_ACK));
    add_event(make_event(KIND_HOLD, 0, 0, 0, 0, 1));
    add_event(make_event(KIND_OFFER, 2));
    add_event(make_event(KIND_HOLD));
    add_event(make_event(KIND_ACK_OK));
    add_event(make_event(KIND_QUERY_SENT));
    add_event(make_event(KIND_TIMEOUT));
    add_event(make_event(KIND_TIMEOUT));
    add_event(make_event(KIND_ACK_OK));
    add_event(make_event(KIND_ACK_ERROR, 0, 0, 0, 255));
    // skipped tool change line ends the stream on an empty fifo
    add_event(make_event(KIND_START, 0, 0, 2));
    add_event(make_event(KIND_OFFER, 0, 1));
    add_event(make_event(KIND_TOOL_ACK));
    add_event(make_event(KIND_OFFER, 3));
    add_event(make_event(KIND_OFFER, 3));
    add_event(make_event(KIND_ACK_OK));
    // streaming error, then start ignored while in error
    add_event(make_event(KIND_START, 0, 0, 5));
    add_event(make_event(KIND_OFFER, 10));
    add_event(make_event(KIND_OFFER, 10));
    add_event(make_event(KIND_ACK_ERROR, 0, 0, 0, 8'hA5));
    add_event(make_event(KIND_START, 0, 0, 3));
    add_event(make_event(KIND_DISCONNECT));
    add_event(make_event(KIND_START, 0, 0, 4));
    add_event(make_event(KIND_ALARM));
    add_event(make_event(KIND_STATUS_SEEN));
    add_event(make_event(KIND_CLEAR_ERROR));
    add_event(make_event(KIND_SPARE));
    wait_idle();

    // default limits, with a long receiver hold-off while events keep coming
    write_reg(CFG_TIMEOUT_LIMIT, 11'd25);
    add_random_phase(200);
    long_hold_seq++;
    wait_idle();

    // largest buffer of the run and shortest timeout, more offers than the fifo depth
    write_reg(CFG_RX_BUFFER_BYTES, 11'd1024);
    write_reg(CFG_TIMEOUT_LIMIT, 11'd1);
    add_event(make_event(KIND_CLEAR_ERROR));
    add_event(make_event(KIND_START, 0, 0, 300));
    repeat (CREDIT_DEPTH + 2)
      add_event(make_event(KIND_OFFER, $urandom_range(0, 6)));
    repeat (CREDIT_DEPTH + 2) add_event(rand_event(KIND_ACK_OK));
    add_random_phase(100);
    wait_idle();

    // smallest buffer and longest timeout
    write_reg(CFG_RX_BUFFER_BYTES, 11'd16);
    write_reg(CFG_TIMEOUT_LIMIT, 11'd255);
    add_random_phase(200);
    long_hold_seq++;
    wait_idle();

    // random settings
    write_reg(CFG_RX_BUFFER_BYTES, 11'($urandom_range(16, 1024)));
    write_reg(CFG_TIMEOUT_LIMIT, 11'($urandom_range(1, 255)));
    add_random_phase(150);
    wait_idle();

    // sender and receiver free running, events back to back
    free_run = 1'b1;
    add_random_phase(100);
    wait_idle();
    free_run = 1'b0;

    repeat (8) @(posedge clk);
    if (st_wr != st_rd) begin
      mismatches++;
      $display("%0t ns: results expected %0d more actual 0", $time, st_wr - st_rd);
    end
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
